### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("next-cycle check failed");

`endif

### rtl/rm_edf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rm_edf_pkg
// Payload types, codes and fixed widths of the RM/EDF tick scheduler.
// ----------------------------------------------------------------------------
package rm_edf_pkg;

  localparam int TASK_IDX_W = 4;
  localparam int FIELD_W    = 16;
  localparam int CNT_REG_W  = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // Item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 4'd1;

  typedef struct packed {
    logic                  mode;
    logic [TASK_IDX_W-1:0] task_index;
    logic [FIELD_W-1:0]    period;
    logic [FIELD_W-1:0]    exec_time;
    logic [FIELD_W-1:0]    rel_deadline;
  } in_item_t;

  typedef struct packed {
    logic [TASK_IDX_W-1:0] running_task;
    logic                  busy_res;
    logic                  job_done;
    logic                  deadline_miss;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS1,
    ST_PASS2,
    ST_FIN
  } state_t;

endpackage

### rtl/rm_edf_tick_scheduler.sv
`timescale 1ns / 1ps
// A load beat gives no result. A tick beat sweeps the active entries in PASS1, then
//   in PASS2, waits in FIN until the output register is free and then registers its
//   result; the next beat is taken only once the FSM is back in IDLE.
// Throughput is set by the single read port of the state memory: one entry per
//   cycle, two sweeps per tick (release/select, then run/advance).
// Reset: synchronous active-low; clears policy, task count, FSM and entry valid bits.
// ----------------------------------------------------------------------------
// rm_edf_tick_scheduler
// Periodic task scheduler, rate monotonic or EDF, advanced one tick per tick beat.
// ----------------------------------------------------------------------------
module rm_edf_tick_scheduler
  import rm_edf_pkg::*;
#(
  parameter int MAX_TASK_COUNT = 16,
  parameter int TIME_BITS      = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_TASK_COUNT);
  localparam int CNT_W = $clog2(MAX_TASK_COUNT + 1);
  localparam int PW    = (IDX_W > TASK_IDX_W) ? IDX_W : TASK_IDX_W;

  // Static task parameters, written by load beats only
  typedef struct packed {
    logic [TIME_BITS-1:0] period;
    logic [TIME_BITS-1:0] exec;
    logic [TIME_BITS-1:0] reldl;
  } stat_t;

  // Per-entry run state
  typedef struct packed {
    logic [TIME_BITS-1:0] work;
    logic [TIME_BITS-1:0] ttd;
    logic [TIME_BITS-1:0] ttr;
  } dyn_t;

  // --------------------------------------------------------------------------
  // Config registers (user must write them only while the block is quiet; not enforced)
  // --------------------------------------------------------------------------
  logic                 policy_r;
  logic [CNT_REG_W-1:0] task_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= 1'b0;
      task_count_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POLICY:     policy_r     <= cfg_data[0];
        REG_TASK_COUNT: task_count_r <= cfg_data[CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Memories: parameter table and run-state table, registered read.
  // Run-state entries carry valid bits; an entry never written reads as zero.
  // --------------------------------------------------------------------------
  stat_t                   st_mem [MAX_TASK_COUNT];
  dyn_t                    dyn_mem[MAX_TASK_COUNT];
  logic [MAX_TASK_COUNT-1:0] dyn_vld_r;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  stat_t            st_q_r;
  dyn_t             dyn_q_r;
  logic             q_vld_r;

  logic             st_we;
  logic [IDX_W-1:0] st_wa;
  stat_t            st_wd;
  logic             dyn_we;
  logic [IDX_W-1:0] dyn_wa;
  dyn_t             dyn_wd;

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    if (rd_en) begin
      st_q_r <= st_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (dyn_we) begin
      dyn_mem[dyn_wa] <= dyn_wd;
    end
    if (rd_en) begin
      dyn_q_r <= dyn_mem[rd_addr];
      q_vld_r <= dyn_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dyn_vld_r <= '0;
    end else if (dyn_we) begin
      dyn_vld_r[dyn_wa] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // PASS1 sweeps entries: release due jobs, track best candidate.
  // PASS2 sweeps entries: run the pick one unit, count down, drop late jobs.
  // Reads issue at cnt_r; the entry is modified and written back in the cycle
  // after (rv_r). Sweeps never touch the same entry twice in flight, and the
  // last PASS1 write lands before the first PASS2 read is sampled.
  // --------------------------------------------------------------------------
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] lim_r, lim_nxt;
  logic             rv_r, rv_nxt;
  logic [IDX_W-1:0] ridx_r, ridx_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;
  logic [TIME_BITS-1:0] best_r, best_nxt;
  logic             miss_r, miss_nxt;
  logic             done_r, done_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [PW-1:0]    pick_ext;
  assign pick_ext = PW'(pick_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    lim_r      <= lim_nxt;
    ridx_r     <= ridx_nxt;
    found_r    <= found_nxt;
    pick_r     <= pick_nxt;
    best_r     <= best_nxt;
    miss_r     <= miss_nxt;
    done_r     <= done_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    logic [TIME_BITS-1:0] w;
    logic [TIME_BITS-1:0] d;
    logic [TIME_BITS-1:0] r;
    logic [TIME_BITS-1:0] key;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lim_nxt       = lim_r;
    rv_nxt        = 1'b0;
    ridx_nxt      = ridx_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    best_nxt      = best_r;
    miss_nxt      = miss_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = cnt_r[IDX_W-1:0];
    st_we         = 1'b0;
    st_wa         = IDX_W'(in_data.task_index);
    st_wd.period  = TIME_BITS'(in_data.period);
    st_wd.exec    = TIME_BITS'(in_data.exec_time);
    st_wd.reldl   = TIME_BITS'(in_data.rel_deadline);
    dyn_we        = 1'b0;
    dyn_wa        = ridx_r;
    dyn_wd        = '0;

    // Entry read last cycle; unwritten run state counts as zero
    w   = q_vld_r ? dyn_q_r.work : '0;
    d   = q_vld_r ? dyn_q_r.ttd  : '0;
    r   = q_vld_r ? dyn_q_r.ttr  : '0;
    key = '0;

    if (rv_r && state_r == ST_PASS1) begin
      if (r == '0) begin
        // release; unfinished old job counts as missed
        if (w != '0) begin
          miss_nxt = 1'b1;
        end
        w = st_q_r.exec;
        d = st_q_r.reldl;
        r = st_q_r.period;
      end
      key = policy_r ? d : st_q_r.period;
      if (w != '0 && (!found_r || key < best_r)) begin
        found_nxt = 1'b1;
        best_nxt  = key;
        pick_nxt  = ridx_r;
      end
      dyn_we = 1'b1;
      dyn_wd = '{work: w, ttd: d, ttr: r};
    end

    if (rv_r && state_r == ST_PASS2) begin
      if (found_r && ridx_r == pick_r) begin
        w = w - TIME_BITS'(1);
        if (w == '0) begin
          done_nxt = 1'b1;
        end
      end
      if (r != '0) begin
        r = r - TIME_BITS'(1);
      end
      if (d != '0) begin
        d = d - TIME_BITS'(1);
      end
      if (w != '0 && d == '0) begin
        miss_nxt = 1'b1;
        w        = '0;
      end
      dyn_we = 1'b1;
      dyn_wd = '{work: w, ttd: d, ttr: r};
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.mode == MODE_LOAD) begin
            if (int'(in_data.task_index) < MAX_TASK_COUNT) begin
              st_we  = 1'b1;
              dyn_we = 1'b1;
              dyn_wa = IDX_W'(in_data.task_index);
              dyn_wd = '0;
            end
          end else begin
            if (int'(task_count_r) > MAX_TASK_COUNT) begin
              lim_nxt = CNT_W'(MAX_TASK_COUNT);
            end else begin
              lim_nxt = CNT_W'(task_count_r);
            end
            cnt_nxt   = '0;
            found_nxt = 1'b0;
            pick_nxt  = '0;
            best_nxt  = '0;
            miss_nxt  = 1'b0;
            done_nxt  = 1'b0;
            state_nxt = ST_PASS1;
          end
        end
      end
      ST_PASS1: begin
        if (cnt_r < lim_r) begin
          rd_en    = 1'b1;
          rv_nxt   = 1'b1;
          ridx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt  = cnt_r + CNT_W'(1);
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_PASS2;
        end
      end
      ST_PASS2: begin
        if (cnt_r < lim_r) begin
          rd_en    = 1'b1;
          rv_nxt   = 1'b1;
          ridx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt  = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.running_task  = found_r ? pick_ext[TASK_IDX_W-1:0] : '0;
          out_data_nxt.busy_res      = found_r;
          out_data_nxt.job_done      = done_r;
          out_data_nxt.deadline_miss = miss_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/rm_edf_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rm_edf_chk
// Port-level checks of the tick scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rm_edf_chk
  import rm_edf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // stalled result beat holds
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // idle tick reports task zero and no completion
  `ASSERT_IMPL(a_idle_clean, out_valid && !out_data.busy_res,
               out_data.running_task == '0 && !out_data.job_done)

  // completion only on a busy tick
  `ASSERT_IMPL(a_done_busy, out_valid && out_data.job_done, out_data.busy_res)

  // a load beat never produces a result
  `ASSERT_NEXT(a_load_quiet, in_valid && in_ready && in_data.mode == MODE_LOAD,
               !$rose(out_valid))

endmodule

bind rm_edf_tick_scheduler rm_edf_chk u_rm_edf_chk (.*);
